// ===== rtl/sgnms_pkg.sv =====
// Shared types, constants and helpers for the Sobel gradient / non-max suppression block.
// No dependencies; every other file in rtl/ except sgnms_ram imports this package.
package sgnms_pkg;

  localparam int MAX_W      = 1024;              // line buffer width (power of two)
  localparam int COL_W      = $clog2(MAX_W);
  localparam int ROW_W      = 12;
  localparam int RING_DEPTH = 3 * MAX_W;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int PIX_W      = 8;
  localparam int SQ_W       = 21;
  localparam int SEC_W      = 2;
  localparam int GRD_W      = SQ_W + SEC_W;
  localparam int MAG_W      = 11;
  localparam int CNT_W      = 11;
  localparam int G_W        = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int K_W        = 4;
  localparam int ISQ_STEPS  = (SQ_W + 1) / 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [SEC_W-1:0] SEC_HORZ = 2'd0;
  localparam logic [SEC_W-1:0] SEC_D45  = 2'd1;
  localparam logic [SEC_W-1:0] SEC_VERT = 2'd2;
  localparam logic [SEC_W-1:0] SEC_D135 = 2'd3;

  // datapath commands
  localparam logic [3:0] CMD_NOP    = 4'd0;
  localparam logic [3:0] CMD_ACCEPT = 4'd1;
  localparam logic [3:0] CMD_GRD_RD = 4'd2;
  localparam logic [3:0] CMD_GM1    = 4'd3;
  localparam logic [3:0] CMD_GM2    = 4'd4;
  localparam logic [3:0] CMD_GM3    = 4'd5;
  localparam logic [3:0] CMD_GM4    = 4'd6;
  localparam logic [3:0] CMD_GWR    = 4'd7;
  localparam logic [3:0] CMD_RD_CTR = 4'd8;
  localparam logic [3:0] CMD_RD_N1  = 4'd9;
  localparam logic [3:0] CMD_RD_N2  = 4'd10;
  localparam logic [3:0] CMD_CMP    = 4'd11;
  localparam logic [3:0] CMD_SQ     = 4'd12;
  localparam logic [3:0] CMD_OUT    = 4'd13;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] edge_magnitude;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]     op;
    logic [K_W-1:0] k;
    logic           cfg_we;
  } cmd_t;

  typedef struct packed {
    logic at_origin;
    logic gp_gt;
    logic gp_nz;
    logic op_gt;
    logic op_nz;
    logic is_drain;
    logic out_busy;
  } stat_t;

  // signed offset -1/0/+1
  typedef logic signed [1:0] ofs_t;

  function automatic logic [1:0] rm3_inc(logic [1:0] r);
    return (r == 2'd2) ? 2'd0 : r + 2'd1;
  endfunction

  function automatic logic [1:0] rm3_dec(logic [1:0] r);
    return (r == 2'd0) ? 2'd2 : r - 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(logic [1:0] rm3, logic [COL_W-1:0] col,
                                                  ofs_t dr, ofs_t dc);
    logic [1:0]       r;
    logic [COL_W-1:0] c;
    r = (dr == 2'sd1) ? rm3_inc(rm3) : (dr == -2'sd1) ? rm3_dec(rm3) : rm3;
    c = col + {{(COL_W-1){dc[1]}}, dc[0]};
    return {r, c};
  endfunction

  // Sobel taps in read order, the center is not used
  function automatic ofs_t tap_dr(logic [K_W-1:0] k);
    case (k)
      4'd0, 4'd1, 4'd2: return -2'sd1;
      4'd3, 4'd4:       return 2'sd0;
      default:          return 2'sd1;
    endcase
  endfunction

  function automatic ofs_t tap_dc(logic [K_W-1:0] k);
    case (k)
      4'd0, 4'd3, 4'd5: return -2'sd1;
      4'd1, 4'd6:       return 2'sd0;
      default:          return 2'sd1;
    endcase
  endfunction

  // neighbors along a sector; second selects the opposite side
  function automatic ofs_t nbr_dr(logic [SEC_W-1:0] sec, logic second);
    case (sec)
      SEC_HORZ: return 2'sd0;
      default:  return second ? 2'sd1 : -2'sd1;
    endcase
  endfunction

  function automatic ofs_t nbr_dc(logic [SEC_W-1:0] sec, logic second);
    case (sec)
      SEC_HORZ: return second ? 2'sd1 : -2'sd1;
      SEC_D45:  return second ? -2'sd1 : 2'sd1;
      SEC_VERT: return 2'sd0;
      default:  return second ? 2'sd1 : -2'sd1;
    endcase
  endfunction

endpackage

// ===== rtl/sgnms_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sgnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sgnms_ctrl.sv =====
// Sequencer for the Sobel / non-max suppression block: steps one request through
// gradient, neighbor reads, square root and output. Depends on sgnms_pkg.
module sgnms_ctrl import sgnms_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  cfg_valid,
  input  stat_t stat,
  output logic  in_stall,
  output logic  cfg_ready,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHKG  = 5'd1;
  localparam logic [4:0] S_GRD   = 5'd2;
  localparam logic [4:0] S_GLAST = 5'd3;
  localparam logic [4:0] S_GM1   = 5'd4;
  localparam logic [4:0] S_GM2   = 5'd5;
  localparam logic [4:0] S_GM3   = 5'd6;
  localparam logic [4:0] S_GM4   = 5'd7;
  localparam logic [4:0] S_GWR   = 5'd8;
  localparam logic [4:0] S_CHKO  = 5'd9;
  localparam logic [4:0] S_ER0   = 5'd10;
  localparam logic [4:0] S_ER1   = 5'd11;
  localparam logic [4:0] S_ER2   = 5'd12;
  localparam logic [4:0] S_ER3   = 5'd13;
  localparam logic [4:0] S_ER4   = 5'd14;
  localparam logic [4:0] S_CMP   = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  localparam logic [K_W-1:0] K_LAST_TAP = 4'd7;
  localparam logic [K_W-1:0] K_LAST_SQ  = K_W'(ISQ_STEPS - 1);

  logic [4:0]     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cmd.op     = CMD_NOP;
    cmd.k      = k_r;
    cmd.cfg_we = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
        end else if (in_valid) begin
          cmd.op    = CMD_ACCEPT;
          state_nxt = S_CHKG;
        end
      end
      S_CHKG: begin
        k_nxt = '0;
        if (stat.is_drain) begin
          if (!stat.at_origin) state_nxt = S_IDLE;
          else if (stat.gp_nz) state_nxt = S_GRD;
          else                 state_nxt = S_CHKO;
        end else begin
          state_nxt = stat.gp_gt ? S_GRD : S_CHKO;
        end
      end
      S_GRD: begin
        cmd.op = CMD_GRD_RD;
        k_nxt  = k_r + 4'd1;
        if (k_r == K_LAST_TAP) state_nxt = S_GLAST;
      end
      S_GLAST: state_nxt = S_GM1;
      S_GM1: begin
        cmd.op    = CMD_GM1;
        state_nxt = S_GM2;
      end
      S_GM2: begin
        cmd.op    = CMD_GM2;
        state_nxt = S_GM3;
      end
      S_GM3: begin
        cmd.op    = CMD_GM3;
        state_nxt = S_GM4;
      end
      S_GM4: begin
        cmd.op    = CMD_GM4;
        state_nxt = S_GWR;
      end
      S_GWR: begin
        cmd.op    = CMD_GWR;
        state_nxt = S_CHKO;
      end
      S_CHKO: begin
        if (stat.is_drain) begin
          state_nxt = (stat.op_nz && (stat.op_gt || !stat.gp_nz)) ? S_ER0 : S_IDLE;
        end else begin
          state_nxt = stat.op_gt ? S_ER0 : S_IDLE;
        end
      end
      S_ER0: begin
        cmd.op    = CMD_RD_CTR;
        state_nxt = S_ER1;
      end
      S_ER1: state_nxt = S_ER2;
      S_ER2: begin
        cmd.op    = CMD_RD_N1;
        state_nxt = S_ER3;
      end
      S_ER3: begin
        cmd.op    = CMD_RD_N2;
        state_nxt = S_ER4;
      end
      S_ER4: state_nxt = S_CMP;
      S_CMP: begin
        cmd.op    = CMD_CMP;
        k_nxt     = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = CMD_SQ;
        k_nxt  = k_r + 4'd1;
        if (k_r == K_LAST_SQ) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op = CMD_OUT;
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== rtl/sgnms_dp.sv =====
// Datapath: frame position counters, line rings, Sobel accumulate, sector test,
// neighbor compare, digit-by-digit square root and output register.
// Depends on sgnms_pkg and sgnms_ram.
module sgnms_dp import sgnms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  in_item_t              in_data,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output stat_t                 stat,
  output logic                  out_valid,
  output out_item_t             out_data
);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [1:0]       rm3;
    logic [COL_W-1:0] col;
  } pos_t;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_CTR  = 2'd1;
  localparam logic [1:0] TAG_N1   = 2'd2;
  localparam logic [1:0] TAG_N2   = 2'd3;

  logic [FW_W-1:0] fw_r, w_eff;
  logic [FH_W-1:0] fh_r, h_eff;
  pos_t            ip_r, gp_pos_r, op_pos_r;
  logic [CNT_W-1:0] gcnt_r, ocnt_r;
  logic            drain_r;

  // rings
  logic             pix_we;
  logic [PIX_W-1:0] pix_q;
  logic [ADDR_W-1:0] pix_raddr;
  logic             grd_we;
  logic [GRD_W-1:0] grd_wdata, grd_q;
  logic [ADDR_W-1:0] grd_raddr;

  // read tagging
  logic           pix_tag_r;
  logic [K_W-1:0] tap_r;
  logic [1:0]     grd_tag_r, grd_tag_nxt;

  // gradient
  logic signed [G_W-1:0] gx_r, gy_r, pv1, pv2, tx, ty;
  ofs_t                  a_dr, a_dc;
  logic [MAG_W-1:0]      ax_c, ay_c, ax_r, ay_r, df_c;
  logic                  xpos_r;
  logic [SQ_W-1:0]       p1_r, sq_r, d_r;
  logic [SQ_W:0]         s_r, two_c;
  logic [2*MAG_W-1:0]    pax, pay, pdf;
  logic [MAG_W:0]        sum_c;
  logic [2*MAG_W+1:0]    psum;
  logic [SEC_W-1:0]      sec_c;

  // emit
  logic [SQ_W-1:0]  m_r, n1_r, n2_r;
  logic [SEC_W-1:0] sec_r;
  logic             keep_r;
  logic [SQ_W-1:0]  v_r;
  logic [SQ_W:0]    res_r, rb_c;
  logic [SQ_W-1:0]  bit_r;

  logic      out_load;
  logic      out_valid_r;
  out_item_t out_r;

  function automatic pos_t adv(pos_t p, logic [FW_W-1:0] w, logic [FH_W-1:0] h);
    pos_t q;
    q = p;
    if (({1'b0, p.col} + 11'd1) >= w) begin
      q.col = '0;
      if ((p.row + 12'd1) >= h) begin
        q.row = '0;
        q.rm3 = 2'd0;
      end else begin
        q.row = p.row + 12'd1;
        q.rm3 = rm3_inc(p.rm3);
      end
    end else begin
      q.col = p.col + 10'd1;
    end
    return q;
  endfunction

  function automatic logic interior(pos_t p, logic [FW_W-1:0] w, logic [FH_W-1:0] h);
    return (p.row != '0) && ((p.row + 12'd1) < h) &&
           (p.col != '0) && (({1'b0, p.col} + 11'd1) < w);
  endfunction

  assign w_eff = (fw_r < 11'd3) ? 11'd3 : (fw_r > FW_W'(MAX_W)) ? FW_W'(MAX_W) : fw_r;
  assign h_eff = (fh_r < 12'd3) ? 12'd3 : fh_r;

  assign stat.at_origin = (ip_r.row == '0) && (ip_r.col == '0);
  assign stat.gp_gt     = {1'b0, gcnt_r} > ({1'b0, w_eff} + 12'd1);
  assign stat.gp_nz     = (gcnt_r != '0);
  assign stat.op_gt     = {1'b0, ocnt_r} > ({1'b0, w_eff} + 12'd1);
  assign stat.op_nz     = (ocnt_r != '0);
  assign stat.is_drain  = drain_r;
  assign stat.out_busy  = out_valid_r && out_stall;

  // ---- line rings ----
  assign pix_we    = (cmd.op == CMD_ACCEPT) && (in_data.op == OP_PIXEL);
  assign pix_raddr = ring_addr(gp_pos_r.rm3, gp_pos_r.col, tap_dr(cmd.k), tap_dc(cmd.k));

  sgnms_ram #(.WIDTH(PIX_W), .DEPTH(RING_DEPTH)) u_pix_ring (
    .clk   (clk),
    .we    (pix_we),
    .waddr ({ip_r.rm3, ip_r.col}),
    .wdata (in_data.pixel),
    .raddr (pix_raddr),
    .rdata (pix_q)
  );

  assign grd_we    = (cmd.op == CMD_GWR);
  assign grd_wdata = interior(gp_pos_r, w_eff, h_eff) ? {sq_r, sec_c} : '0;

  always_comb begin
    grd_tag_nxt = TAG_NONE;
    grd_raddr   = {op_pos_r.rm3, op_pos_r.col};
    case (cmd.op)
      CMD_RD_CTR: grd_tag_nxt = TAG_CTR;
      CMD_RD_N1: begin
        grd_tag_nxt = TAG_N1;
        grd_raddr   = ring_addr(op_pos_r.rm3, op_pos_r.col,
                                nbr_dr(sec_r, 1'b0), nbr_dc(sec_r, 1'b0));
      end
      CMD_RD_N2: begin
        grd_tag_nxt = TAG_N2;
        grd_raddr   = ring_addr(op_pos_r.rm3, op_pos_r.col,
                                nbr_dr(sec_r, 1'b1), nbr_dc(sec_r, 1'b1));
      end
      default: ;
    endcase
  end

  sgnms_ram #(.WIDTH(GRD_W), .DEPTH(RING_DEPTH)) u_grd_ring (
    .clk   (clk),
    .we    (grd_we),
    .waddr ({gp_pos_r.rm3, gp_pos_r.col}),
    .wdata (grd_wdata),
    .raddr (grd_raddr),
    .rdata (grd_q)
  );

  // ---- Sobel accumulate: tap weight 2 on the center row/column ----
  assign a_dr = tap_dr(tap_r);
  assign a_dc = tap_dc(tap_r);
  assign pv1  = $signed({{(G_W-PIX_W){1'b0}}, pix_q});
  assign pv2  = $signed({{(G_W-PIX_W-1){1'b0}}, pix_q, 1'b0});
  assign tx   = (a_dr == 2'sd0) ? pv2 : pv1;
  assign ty   = (a_dc == 2'sd0) ? pv2 : pv1;

  // ---- magnitude and sector ----
  assign ax_c  = gx_r[G_W-1] ? MAG_W'(-gx_r) : gx_r[MAG_W-1:0];
  assign ay_c  = gy_r[G_W-1] ? MAG_W'(-gy_r) : gy_r[MAG_W-1:0];
  assign pax   = ax_c * ax_c;
  assign pay   = ay_r * ay_r;
  assign sum_c = {1'b0, ax_r} + {1'b0, ay_r};
  assign psum  = sum_c * sum_c;
  assign df_c  = ay_r - ax_r;
  assign pdf   = df_c * df_c;
  assign two_c = {p1_r, 1'b0};

  always_comb begin
    if (s_r <= two_c)                                 sec_c = SEC_HORZ;
    else if ((ay_r > ax_r) && ({1'b0, d_r} > two_c)) sec_c = SEC_VERT;
    else if (xpos_r)                                 sec_c = SEC_D45;
    else                                             sec_c = SEC_D135;
  end

  // ---- square root step ----
  assign rb_c = res_r + {1'b0, bit_r};

  // ---- output register ----
  assign out_load  = (cmd.op == CMD_OUT) && !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_W'(MAX_W);
      fh_r        <= 12'd4095;
      ip_r        <= '0;
      gp_pos_r    <= '0;
      op_pos_r    <= '0;
      gcnt_r      <= '0;
      ocnt_r      <= '0;
      drain_r     <= 1'b0;
      pix_tag_r   <= 1'b0;
      grd_tag_r   <= TAG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      pix_tag_r <= (cmd.op == CMD_GRD_RD);
      grd_tag_r <= grd_tag_nxt;
      if (cmd.cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
            if (cfg_index == REG_FRAME_WIDTH) fw_r <= cfg_data[FW_W-1:0];
            else                              fh_r <= cfg_data[FH_W-1:0];
            ip_r     <= '0;
            gp_pos_r <= '0;
            op_pos_r <= '0;
            gcnt_r   <= '0;
            ocnt_r   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.op == CMD_ACCEPT) begin
        drain_r <= in_data.op;
        if (in_data.op == OP_PIXEL) begin
          ip_r   <= adv(ip_r, w_eff, h_eff);
          gcnt_r <= gcnt_r + 11'd1;
        end
      end
      if (cmd.op == CMD_GWR) begin
        gp_pos_r <= adv(gp_pos_r, w_eff, h_eff);
        gcnt_r   <= gcnt_r - 11'd1;
        ocnt_r   <= ocnt_r + 11'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        op_pos_r    <= adv(op_pos_r, w_eff, h_eff);
        ocnt_r      <= ocnt_r - 11'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tap_r <= cmd.k;
    if ((cmd.op == CMD_GRD_RD) && (cmd.k == '0)) begin
      gx_r <= '0;
      gy_r <= '0;
    end else if (pix_tag_r) begin
      if (a_dc == 2'sd1)       gx_r <= gx_r + tx;
      else if (a_dc == -2'sd1) gx_r <= gx_r - tx;
      if (a_dr == 2'sd1)       gy_r <= gy_r + ty;
      else if (a_dr == -2'sd1) gy_r <= gy_r - ty;
    end
    case (cmd.op)
      CMD_GM1: begin
        ax_r   <= ax_c;
        ay_r   <= ay_c;
        p1_r   <= pax[SQ_W-1:0];
        xpos_r <= gy_r[G_W-1] ? gx_r[G_W-1] : (!gx_r[G_W-1] && (gx_r != '0));
      end
      CMD_GM2: sq_r <= p1_r + pay[SQ_W-1:0];
      CMD_GM3: s_r  <= psum[SQ_W:0];
      CMD_GM4: d_r  <= pdf[SQ_W-1:0];
      CMD_CMP: begin
        keep_r <= interior(op_pos_r, w_eff, h_eff) && (m_r > n1_r) && (m_r > n2_r);
        v_r    <= m_r;
        res_r  <= '0;
        bit_r  <= {1'b1, {(SQ_W-1){1'b0}}};
      end
      CMD_SQ: begin
        if ({1'b0, v_r} >= rb_c) begin
          v_r   <= v_r - rb_c[SQ_W-1:0];
          res_r <= (res_r >> 1) + {1'b0, bit_r};
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
    case (grd_tag_r)
      TAG_CTR: begin
        m_r   <= grd_q[GRD_W-1:SEC_W];
        sec_r <= grd_q[SEC_W-1:0];
      end
      TAG_N1:  n1_r <= grd_q[GRD_W-1:SEC_W];
      TAG_N2:  n2_r <= grd_q[GRD_W-1:SEC_W];
      default: ;
    endcase
    if (out_load) begin
      out_r.edge_magnitude <= keep_r ? res_r[MAG_W-1:0] : '0;
      out_r.frame_last     <= (op_pos_r.row == (h_eff - 12'd1)) &&
                              ({1'b0, op_pos_r.col} == (w_eff - 11'd1));
    end
  end

  // pending counts stay within one line plus the window overhang
  a_gcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, gcnt_r} <= ({1'b0, w_eff} + 12'd2))
    else $error("gradient pending count out of range");

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ocnt_r} <= ({1'b0, w_eff} + 12'd2))
    else $error("output pending count out of range");

  a_load_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (ocnt_r != '0))
    else $error("output emitted with nothing pending");

endmodule

// ===== rtl/sobel_gradient_nonmax_suppress.sv =====
// Top level of the Sobel gradient with non-maximum suppression block.
// Depends on sgnms_pkg, sgnms_ctrl, sgnms_dp (and sgnms_ram through sgnms_dp).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | input     | in_valid / in_stall  | in_item_t  {op, pixel}
//  out_    | output    | out_valid / out_stall| out_item_t {edge_magnitude, frame_last}
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index (0 width, 1 height), cfg_data
//
// Sequencing: a request is taken only while the sequencer is idle. A pixel request that
// forms no gradient and no output passes accept, gradient check and output check, a drain
// tick away from the frame origin ends after the gradient check; a gradient adds 8
// pixel-ring reads, accumulate, 4 multiply steps and a ring write; an output adds 3
// gradient-ring reads with 2 read-wait steps, compare, 11 square-root steps, output load.
// The single read port of each line ring and the shared square-root unit set this order.
// Reset: synchronous active low; counters, frame registers and valid flags reset, payload registers and rings do not.
// Stalls: the result register holds while out_stall is high; a new request is still
// accepted, and the sequencer waits in its output step only if the register is full.
module sobel_gradient_nonmax_suppress import sgnms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;   // sequencer -> datapath
  stat_t stat;  // datapath -> sequencer

  sgnms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  sgnms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_sobel_gradient_nonmax_suppress.sv =====
// Self-checking bench for the Sobel gradient / non-maximum suppression block.
// Needs sgnms_pkg and the RTL under rtl/; a directed table, then random frames.
module tb_sobel_gradient_nonmax_suppress;
  import sgnms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE = 1024;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RAND_PIXELS = 700;
  localparam int SETTLE = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sobel_gradient_nonmax_suppress uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Edge predictor: own copy of the line rings, frame registers and positions.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] pix_ring [3*LINE];
  logic [SQ_W-1:0]  mag2_ring[3*LINE];
  logic [SEC_W-1:0] sec_ring [3*LINE];
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  int unsigned in_r, in_c, gr_r, gr_c, out_r, out_c, grad_wait, out_wait;

  out_item_t edge_q[$];     // outputs still owed by the block
  int        errors;
  int        cycles;
  bit        quiet;         // no idling in the final stretch

  function automatic int unsigned frame_w();
    if (width_reg < 3) return 3;
    if (width_reg > LINE) return LINE;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic int unsigned ring_slot(int unsigned r, int unsigned c);
    if (c >= LINE) c = 0;
    return (r % 3) * LINE + c;
  endfunction

  function automatic bit is_interior(int unsigned r, int unsigned c);
    return r >= 1 && r + 1 < frame_h() && c >= 1 && c + 1 < frame_w();
  endfunction

  task automatic step_pos(inout int unsigned r, inout int unsigned c);
    c++;
    if (c >= frame_w()) begin
      c = 0;
      r++;
      if (r >= frame_h()) r = 0;
    end
  endtask

  function automatic int tap(int unsigned r, int unsigned c);
    return int'(pix_ring[ring_slot(r, c)]);
  endfunction

  // direction quantization by exact integer bounds
  function automatic logic [SEC_W-1:0] direction(int gx, int gy);
    longint x, y, ax, two;
    x = gx;
    y = gy;
    if (y < 0) begin
      x = -x;
      y = -y;
    end
    ax = (x < 0) ? -x : x;
    two = 2 * ax * ax;
    if ((ax + y) * (ax + y) <= two) return SEC_HORZ;
    if (y > ax && (y - ax) * (y - ax) > two) return SEC_VERT;
    return (x > 0) ? SEC_D45 : SEC_D135;
  endfunction

  function automatic logic [MAG_W-1:0] floor_sqrt(int unsigned v);
    int unsigned res, bitv;
    res = 0;
    bitv = 1 << 30;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[MAG_W-1:0];
  endfunction

  task automatic form_gradient();
    int unsigned r, c, m2;
    int gx, gy;
    logic [SEC_W-1:0] s;
    r = gr_r;
    c = gr_c;
    m2 = 0;
    s = SEC_HORZ;
    if (is_interior(r, c)) begin
      gx = (tap(r-1, c+1) + 2*tap(r, c+1) + tap(r+1, c+1))
         - (tap(r-1, c-1) + 2*tap(r, c-1) + tap(r+1, c-1));
      gy = (tap(r+1, c-1) + 2*tap(r+1, c) + tap(r+1, c+1))
         - (tap(r-1, c-1) + 2*tap(r-1, c) + tap(r-1, c+1));
      m2 = gx*gx + gy*gy;
      s = direction(gx, gy);
    end
    mag2_ring[ring_slot(r, c)] = m2[SQ_W-1:0];
    sec_ring[ring_slot(r, c)] = s;
    step_pos(gr_r, gr_c);
    grad_wait--;
    out_wait++;
  endtask

  task automatic emit_edge(output out_item_t res);
    int unsigned r, c, m, n1, n2;
    r = out_r;
    c = out_c;
    res = '0;
    if (is_interior(r, c)) begin
      m = mag2_ring[ring_slot(r, c)];
      case (sec_ring[ring_slot(r, c)])
        SEC_HORZ: begin
          n1 = mag2_ring[ring_slot(r, c-1)];
          n2 = mag2_ring[ring_slot(r, c+1)];
        end
        SEC_D45: begin
          n1 = mag2_ring[ring_slot(r-1, c+1)];
          n2 = mag2_ring[ring_slot(r+1, c-1)];
        end
        SEC_VERT: begin
          n1 = mag2_ring[ring_slot(r-1, c)];
          n2 = mag2_ring[ring_slot(r+1, c)];
        end
        default: begin
          n1 = mag2_ring[ring_slot(r-1, c-1)];
          n2 = mag2_ring[ring_slot(r+1, c+1)];
        end
      endcase
      if (m > n1 && m > n2) res.edge_magnitude = floor_sqrt(m);
    end
    res.frame_last = (r == frame_h() - 1 && c == frame_w() - 1);
    step_pos(out_r, out_c);
    out_wait--;
  endtask

  // one accepted request; got is set when it yields an output
  task automatic predict_edge(input in_item_t it, output bit got, output out_item_t res);
    int unsigned w;
    w = frame_w();
    got = 0;
    res = '0;
    if (it.op == OP_PIXEL) begin
      pix_ring[ring_slot(in_r, in_c)] = it.pixel;
      step_pos(in_r, in_c);
      grad_wait++;
      if (grad_wait > w + 1) form_gradient();
      if (out_wait > w + 1) begin
        emit_edge(res);
        got = 1;
      end
    end else if (in_r == 0 && in_c == 0) begin
      // drain tick at a frame boundary flushes the tail
      if (grad_wait > 0) form_gradient();
      if (out_wait > 0 && (out_wait > w + 1 || grad_wait == 0)) begin
        emit_edge(res);
        got = 1;
      end
    end
  endtask

  task automatic restart_stream();
    in_r = 0; in_c = 0; gr_r = 0; gr_c = 0; out_r = 0; out_c = 0;
    grad_wait = 0; out_wait = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (edge_q.size() == 0) begin
        report("output with nothing expected");
      end else begin
        out_item_t e;
        e = edge_q.pop_front();
        if (out_data.edge_magnitude !== e.edge_magnitude)
          report($sformatf("edge_magnitude %0d, expected %0d",
                           out_data.edge_magnitude, e.edge_magnitude));
        if (out_data.frame_last !== e.frame_last)
          report($sformatf("frame_last %0b, expected %0b",
                           out_data.frame_last, e.frame_last));
      end
    end
  end

  // receiver backpressure in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // known = 1: every output of the request is a border output, magnitude zero
  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
    logic       known;
  } dir_row_t;

  localparam int DIR_ROWS = 19;
  // 3x3 frame: drain with nothing pending, nine pixels (eight extreme), full flush,
  // then a drain with nothing left; the center output is left to the predictor
  dir_row_t dir_tab[DIR_ROWS] = '{
    '{OP_DRAIN, 8'hA5, 1'b1},
    '{OP_PIXEL, 8'h00, 1'b1}, '{OP_PIXEL, 8'hFF, 1'b1}, '{OP_PIXEL, 8'h00, 1'b1},
    '{OP_PIXEL, 8'hFF, 1'b1}, '{OP_PIXEL, 8'h00, 1'b1}, '{OP_PIXEL, 8'hFF, 1'b1},
    '{OP_PIXEL, 8'h00, 1'b1}, '{OP_PIXEL, 8'hFF, 1'b1}, '{OP_PIXEL, 8'h55, 1'b1},
    '{OP_DRAIN, 8'h00, 1'b1}, '{OP_DRAIN, 8'hFF, 1'b1}, '{OP_DRAIN, 8'h00, 1'b1},
    '{OP_DRAIN, 8'h00, 1'b0}, '{OP_DRAIN, 8'h00, 1'b1}, '{OP_DRAIN, 8'h00, 1'b1},
    '{OP_DRAIN, 8'h00, 1'b1}, '{OP_DRAIN, 8'h00, 1'b1}, '{OP_DRAIN, 8'h00, 1'b1}
  };

  task automatic send_request(input in_item_t it, input bit known);
    bit got;
    out_item_t res;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_edge(it, got, res);
    if (got) begin
      if (known) res.edge_magnitude = '0;
      edge_q.push_back(res);
    end
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    while (edge_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    in_valid  <= 1'b0;
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = d[FW_W-1:0];
      restart_stream();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = d[FH_W-1:0];
      restart_stream();
    end
  endtask

  function automatic logic [7:0] scene_pixel(int mode, int r, int c, int cut);
    case (mode)
      0: return 8'($urandom);
      1: return ((c > cut) ? 8'hF0 : 8'h10) ^ 8'($urandom_range(0, 3));
      2: return ((r + c > cut) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
      3: return ((c - r > cut - 4) ? 8'hC8 : 8'h20) ^ 8'($urandom_range(0, 7));
      default: return (r == cut % 4 + 1 && c == cut) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic run_frames(input int frames, input int mode, inout int pixels);
    int w, h, cut, n;
    in_item_t it;
    w = frame_w();
    h = frame_h();
    for (int f = 0; f < frames; f++) begin
      cut = $urandom_range(1, w - 1);
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < w; c++) begin
          // noise: a stray drain tick
          if ($urandom_range(0, 29) == 0) begin
            it.op = OP_DRAIN;
            it.pixel = 8'($urandom);
            send_request(it, 1'b0);
          end
          it.op = OP_PIXEL;
          it.pixel = scene_pixel(mode, r, c, cut);
          send_request(it, 1'b0);
          pixels++;
          if (pixels > RAND_PIXELS * 9 / 10) quiet = 1;
        end
      end
    end
    // flush, sometimes cut short
    n = 2*w + 2;
    if ($urandom_range(0, 4) == 0) n -= $urandom_range(1, w);
    for (int i = 0; i < n; i++) begin
      it.op = OP_DRAIN;
      it.pixel = 8'($urandom);
      send_request(it, 1'b0);
    end
  endtask

  initial begin
    int pixels, wv, hv;
    in_item_t it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    quiet     = 0;
    pixels    = 0;
    width_reg  = 11'd1024;
    height_reg = 12'd4095;
    restart_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, one interior pixel
    write_reg(REG_FRAME_WIDTH, 12'd3);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.op = dir_tab[i].op;
      it.pixel = dir_tab[i].pixel;
      send_request(it, dir_tab[i].known);
    end

    // widest line: out-of-range width clamps to the line buffer; two rows and a
    // few pixels bring out the first outputs, the next write drops the rest
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < 2*LINE + 8; i++) begin
      it.op = OP_PIXEL;
      it.pixel = scene_pixel(1, i / LINE, i % LINE, LINE / 2);
      send_request(it, 1'b0);
    end

    // tallest frame, left unfinished; the next write drops it
    write_reg(REG_FRAME_WIDTH, 12'd5);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    for (int i = 0; i < 60; i++) begin
      it.op = OP_PIXEL;
      it.pixel = 8'($urandom);
      send_request(it, 1'b0);
    end

    pixels = 0;
    while (pixels < RAND_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       wv = $urandom_range(0, 2);
        1:       wv = $urandom_range(17, 40);
        default: wv = $urandom_range(3, 16);
      endcase
      hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      // unknown register indexes now and then
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wv));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hv));
      end else begin
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hv));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wv));
      end
      run_frames($urandom_range(1, 3), $urandom_range(0, 4), pixels);
    end

    in_valid <= 1'b0;
    wait_quiet();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
